[rtl/mwe_pkg.sv]
// Package for the Microwire serial EEPROM block: constants, command codes,
// the controller/datapath command and status types and the address reduction table.
// Depends on nothing; mwe_ctrl, mwe_dpath and the top level use it.
`default_nettype none

package mwe_pkg;

	localparam int MAX_WORDS_DEF = 256;
	localparam int WORD_BITS = 16;
	localparam int ADDR_BITS = 8;
	localparam int POS_BITS = 5;
	localparam int TAB_DEPTH = 256;

	localparam logic [1:0] SIZE_16 = 2'd0;
	localparam logic [1:0] SIZE_64 = 2'd1;
	localparam logic [1:0] SIZE_256 = 2'd2;

	localparam logic [1:0] OP_EXT = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_ERASE = 2'd3;

	localparam logic [1:0] EXT_WDS = 2'd0;
	localparam logic [1:0] EXT_WRAL = 2'd1;
	localparam logic [1:0] EXT_ERAL = 2'd2;
	localparam logic [1:0] EXT_WEN = 2'd3;

	typedef logic [ADDR_BITS-1:0] mod_tab_t [TAB_DEPTH];

	typedef struct packed {
		logic latch;
		logic step;
		logic load;
		logic push;
	} mwe_cmd_t;

	typedef struct packed {
		logic fetch;
	} mwe_sts_t;

	// Each entry holds its index reduced modulo n, built by a wrapping count.
	function automatic mod_tab_t mod_table(input int n);
		mod_tab_t t;
		int r;
		r = 0;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			t[i] = ADDR_BITS'(r);
			r = r + 1;
			if (r == n) begin
				r = 0;
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

[rtl/mwe_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module mwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/mwe_ctrl.sv]
// Controller state machine for the Microwire serial EEPROM block.
// Depends on mwe_pkg; drives the datapath through mwe_pkg::mwe_cmd_t.
`default_nettype none

module mwe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mwe_pkg::mwe_sts_t sts,
	output mwe_pkg::mwe_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.latch = in_valid;
			ST_EXEC: cmd.step = 1'b1;
			ST_LOAD: cmd.load = 1'b1;
			ST_FIN:  cmd.push = !out_valid_q || out_ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: state_q <= sts.fetch ? ST_LOAD : ST_FIN;
				ST_LOAD: state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.push) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/mwe_dpath.sv]
// Datapath of the Microwire serial EEPROM block: pin sampling, frame decode,
// shift registers, write lock, per-word valid bits and the word store.
// Depends on mwe_pkg and mwe_ram.
`default_nettype none

module mwe_dpath #(
	parameter int MAX_WORDS = mwe_pkg::MAX_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mwe_pkg::mwe_cmd_t cmd,
	output mwe_pkg::mwe_sts_t      sts,
	input  wire logic              chip_select,
	input  wire logic              serial_clock,
	input  wire logic              data_in,
	input  wire logic              cfg_write_en,
	input  wire logic [1:0]        cfg_write_data,
	output logic                   data_out
);

	localparam int AW = $clog2(MAX_WORDS);
	localparam int WB = mwe_pkg::WORD_BITS;
	localparam int PB = mwe_pkg::POS_BITS;
	localparam int NB = mwe_pkg::ADDR_BITS;
	localparam logic [NB:0] MAX_WN = (NB+1)'(MAX_WORDS);
	localparam mwe_pkg::mod_tab_t MOD_TAB = mwe_pkg::mod_table(MAX_WORDS);

	logic                 cs_q, sk_q, di_q;
	logic                 prev_sel_q, prev_clk_q;
	logic                 out_bit_q, locked_q, dout_q;
	logic [PB-1:0]        pos_q;
	logic [1:0]           opc_q, size_q;
	logic [NB-1:0]        addr_q;
	logic [WB-1:0]        shw_q;
	logic [MAX_WORDS-1:0] vld_q;

	logic [PB-1:0]        abits, ibits;
	logic [3:0]           lg;
	logic [NB:0]          span, words;

	logic [NB-1:0]        raw, addr_red;
	logic [1:0]           ext;
	logic [AW-1:0]        idx_new, idx_cur;

	logic [PB-1:0]        pos_d;
	logic [1:0]           opc_d;
	logic [NB-1:0]        addr_d;
	logic [WB-1:0]        shw_d;
	logic                 out_d, lock_d;
	logic                 ram_we, erase_all, fetch;
	logic [AW-1:0]        ram_waddr;
	logic [WB-1:0]        ram_wdata, ram_rdata;

	function automatic logic [NB-1:0] reduce(input logic [NB-1:0] v, input logic [3:0] l);
		logic [NB:0] sp;
		sp = (NB+1)'(1) << l;
		if (sp <= MAX_WN) begin
			return v & NB'(sp - (NB+1)'(1));
		end else begin
			return MOD_TAB[v];
		end
	endfunction

	always_comb begin
		unique case (size_q)
			mwe_pkg::SIZE_16: begin
				abits = PB'(6);
				ibits = PB'(2);
				lg = 4'd4;
			end
			mwe_pkg::SIZE_256: begin
				abits = PB'(8);
				ibits = PB'(0);
				lg = 4'd8;
			end
			default: begin
				abits = PB'(6);
				ibits = PB'(0);
				lg = 4'd6;
			end
		endcase
	end

	assign span = (NB+1)'(1) << lg;
	assign words = (span <= MAX_WN) ? span : MAX_WN;

	assign raw = {addr_q[NB-2:0], di_q};
	assign addr_red = reduce(raw, lg);
	assign idx_new = AW'(addr_red);
	assign idx_cur = AW'(reduce(addr_q, lg));

	always_comb begin
		unique case (size_q)
			mwe_pkg::SIZE_16:  ext = raw[3:2];
			mwe_pkg::SIZE_256: ext = raw[7:6];
			default:           ext = raw[5:4];
		endcase
	end

	always_comb begin
		pos_d = pos_q;
		opc_d = opc_q;
		addr_d = addr_q;
		shw_d = shw_q;
		out_d = out_bit_q;
		lock_d = locked_q;
		ram_we = 1'b0;
		ram_waddr = idx_cur;
		ram_wdata = '0;
		erase_all = 1'b0;
		fetch = 1'b0;
		if (!prev_sel_q && cs_q) begin
			pos_d = '0;
			opc_d = '0;
			addr_d = '0;
			out_d = 1'b1;
		end else if (cs_q && !prev_clk_q && sk_q) begin
			priority if (pos_q == PB'(0)) begin
				pos_d = di_q ? PB'(2) : PB'(1);
			end else if (pos_q == PB'(1)) begin
				if (di_q) begin
					pos_d = PB'(2);
				end
			end else if (pos_q < PB'(4)) begin
				pos_d = pos_q + PB'(1);
				opc_d = {opc_q[0], di_q};
			end else if (pos_q < PB'(4) + ibits) begin
				pos_d = pos_q + PB'(1);
			end else if (pos_q < PB'(4) + abits) begin
				pos_d = pos_q + PB'(1);
				addr_d = raw;
				if (pos_d == PB'(4) + abits) begin
					out_d = 1'b0;
					addr_d = addr_red;
					unique case (opc_q)
						mwe_pkg::OP_EXT: begin
							unique case (ext)
								mwe_pkg::EXT_WDS:  lock_d = 1'b1;
								mwe_pkg::EXT_WRAL: lock_d = locked_q;
								mwe_pkg::EXT_ERAL: erase_all = 1'b1;
								mwe_pkg::EXT_WEN:  lock_d = 1'b0;
							endcase
						end
						mwe_pkg::OP_ERASE: begin
							ram_we = 1'b1;
							ram_waddr = idx_new;
						end
						mwe_pkg::OP_WRITE, mwe_pkg::OP_READ: fetch = 1'b1;
					endcase
				end
			end else if (pos_q < PB'(4) + abits + PB'(WB)) begin
				pos_d = pos_q + PB'(1);
				if (opc_q == mwe_pkg::OP_WRITE) begin
					shw_d = {shw_q[WB-2:0], di_q};
					if (pos_d == PB'(4) + abits + PB'(WB) && !locked_q) begin
						ram_we = 1'b1;
						ram_wdata = shw_d;
					end
				end else if (opc_q == mwe_pkg::OP_READ) begin
					out_d = shw_q[WB-1];
					shw_d = {shw_q[WB-2:0], 1'b0};
				end
			end else begin
				pos_d = pos_q;
			end
		end
	end

	assign sts.fetch = fetch;
	assign data_out = dout_q;

	mwe_ram #(
		.WIDTH(WB),
		.DEPTH(MAX_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.step && ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_new),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mwe_pkg::SIZE_64;
			cs_q <= 1'b0;
			sk_q <= 1'b0;
			di_q <= 1'b0;
			prev_sel_q <= 1'b0;
			prev_clk_q <= 1'b0;
			pos_q <= '0;
			opc_q <= '0;
			addr_q <= '0;
			shw_q <= '0;
			out_bit_q <= 1'b0;
			locked_q <= 1'b0;
			dout_q <= 1'b0;
			vld_q <= '0;
		end else begin
			if (cfg_write_en) begin
				size_q <= cfg_write_data;
			end
			if (cmd.latch) begin
				cs_q <= chip_select;
				sk_q <= serial_clock;
				di_q <= data_in;
			end
			if (cmd.step) begin
				pos_q <= pos_d;
				opc_q <= opc_d;
				addr_q <= addr_d;
				shw_q <= shw_d;
				out_bit_q <= out_d;
				locked_q <= lock_d;
				prev_sel_q <= cs_q;
				prev_clk_q <= sk_q;
				if (erase_all) begin
					for (int k = 0; k < MAX_WORDS; k++) begin
						if ((NB+1)'(k) < words) begin
							vld_q[k] <= 1'b0;
						end
					end
				end else if (ram_we) begin
					vld_q[ram_waddr] <= 1'b1;
				end
			end
			if (cmd.load) begin
				shw_q <= vld_q[idx_cur] ? ram_rdata : '0;
			end
			if (cmd.push) begin
				dout_q <= cs_q & out_bit_q;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/microwire_serial_eeprom.sv]
// Top level of the Microwire serial EEPROM block: controller and datapath.
// Depends on mwe_pkg, mwe_ctrl, mwe_dpath and mwe_ram.
//
// Each request is one sample of the chip select, serial clock and data in pins, and
// yields one data out bit. A sample passes through capture, decode and update, and
// the output register, with a load from the word store in between when it completes
// the address of a read or write command, as the word store has a registered read port.
// One sample is in work at a time; the next is accepted as soon as the previous
// result sits in the output register. The store reads as zero after reset through
// one valid bit per word, so there is no clearing pass; erase all clears those bits at once.
// The size mode register may be written between samples at any time.
`default_nettype none

module microwire_serial_eeprom #(
	parameter int MAX_WORDS = mwe_pkg::MAX_WORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       chip_select,
	input  wire logic       serial_clock,
	input  wire logic       data_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            data_out,
	input  wire logic       cfg_write_en,
	input  wire logic [1:0] cfg_write_data
);

	mwe_pkg::mwe_cmd_t cmd;
	mwe_pkg::mwe_sts_t sts;

	mwe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mwe_dpath #(
		.MAX_WORDS(MAX_WORDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.chip_select   (chip_select),
		.serial_clock  (serial_clock),
		.data_in       (data_in),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.data_out      (data_out)
	);

endmodule

`default_nettype wire

[rtl/mwe_checker.sv]
// Port-level checker for the Microwire serial EEPROM block, bound to the top level.
// Depends only on the ports of microwire_serial_eeprom.
`default_nettype none

module mwe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic data_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out))
		else $error("Output changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("Request accepted while the previous one was in work.");

	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3) || $past(in_valid && in_ready, 4))
		else $error("Result appeared without a matching request.");

endmodule

bind microwire_serial_eeprom mwe_checker u_mwe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.data_out (data_out)
);

`default_nettype wire
